// ===== src/vfa_pkg.sv =====
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types, widths and helper functions of the 3D fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_BITS  = 16;

  // APB register file
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [ADDR_BITS-3:0] REG_THRESHOLD = '0;

  // datapath widths
  localparam int OPD_W  = WORD_BITS + 1;            // multiplier operand
  localparam int PROD_W = 2 * OPD_W;                // exact product
  localparam int SUM_W  = PROD_W + 2;               // sum of three products
  localparam int RES_W  = SUM_W - FRAC_BITS;        // rounded result
  localparam int NZ_W   = WORD_BITS + 2;            // near-zero test operand
  localparam int LEN_W  = WORD_BITS + 1;            // rounded length
  localparam int QUO_W  = FRAC_BITS + 1;            // normalized magnitude

  // square root: one result bit per step
  localparam int SQRT_STAGES    = 8;
  localparam int SQRT_STEPS_PER = WORD_BITS / SQRT_STAGES;
  localparam int SQRT_LAT       = SQRT_STAGES + 1;

  // normalize divider: one quotient bit per step, rounding in the last stage
  localparam int DIV_STEPS     = FRAC_BITS + 1;
  localparam int DIV_STEPS_PER = 3;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_STEPS_PER - 1) / DIV_STEPS_PER;
  localparam int DIV_LAT       = DIV_STAGES;

  localparam int SIDE_N   = SQRT_LAT + DIV_LAT + 1;
  localparam int PIPE_LAT = SIDE_N + 4;

  localparam logic signed [RES_W-1:0] RES_MAX =
    {{(RES_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN =
    {{(RES_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [RES_W-1:0] ONE_RES = RES_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF_SUM = SUM_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_NEG    = 4'd2,
    OP_SCALE  = 4'd3,
    OP_CROSS  = 4'd4,
    OP_DOT    = 4'd5,
    OP_LENGTH = 4'd6,
    OP_NORM   = 4'd7,
    OP_LERP   = 4'd8,
    OP_EQUAL  = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic [3:0]                  op;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic                        equal_flag;
    logic                        saturated;
  } out_t;

  // v counts as zero when v == 0 or |v| < thr
  function automatic logic near_zero(input logic signed [NZ_W-1:0] v,
                                     input logic [THR_BITS-1:0] thr);
    logic [NZ_W-1:0] m;
    m = v[NZ_W-1] ? NZ_W'(-v) : NZ_W'(v);
    return (v == '0) || (m < NZ_W'(thr));
  endfunction

  // add half an LSB, then drop the fraction
  function automatic logic signed [RES_W-1:0] round_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + HALF_SUM;
    return $signed(t[SUM_W-1:FRAC_BITS]);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [RES_W-1:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (v > RES_MAX) begin
      r = RES_MAX[WORD_BITS-1:0];
    end else if (v < RES_MIN) begin
      r = RES_MIN[WORD_BITS-1:0];
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic is_clipped(input logic signed [RES_W-1:0] v);
    return (v > RES_MAX) || (v < RES_MIN);
  endfunction

endpackage

// ===== src/vfa_sqrt.sv =====
// ----------------------------------------------------------------------------
// vfa_sqrt
// Pipelined integer square root, rounded to nearest, one root bit per step.
// ----------------------------------------------------------------------------
module vfa_sqrt (
  input  logic                               clk_i,
  input  logic [2*vfa_pkg::WORD_BITS-1:0]    rad_i,
  output logic [vfa_pkg::LEN_W-1:0]          root_o
);

  localparam int W = vfa_pkg::WORD_BITS;
  localparam int S = vfa_pkg::SQRT_STAGES;

  logic [W+1:0]   rem_q  [S];
  logic [W-1:0]   root_q [S];
  logic [2*W-1:0] rad_q  [S];
  logic [W+1:0]   rem_d  [S];
  logic [W-1:0]   root_d [S];
  logic [2*W-1:0] rad_d  [S];
  logic [vfa_pkg::LEN_W-1:0] root_out_q;

  always_comb begin : stage_comb
    logic [W+1:0]   rem;
    logic [W-1:0]   root;
    logic [2*W-1:0] rad;
    logic [W+1:0]   trial;
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        rem  = '0;
        root = '0;
        rad  = rad_i;
      end else begin
        rem  = rem_q[k-1];
        root = root_q[k-1];
        rad  = rad_q[k-1];
      end
      for (int j = 0; j < vfa_pkg::SQRT_STEPS_PER; j++) begin
        // bring down the next two radicand bits and try 4*root + 1
        rem   = {rem[W-1:0], rad[2*W-1 -: 2]};
        rad   = {rad[2*W-3:0], 2'b00};
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[W-2:0], 1'b1};
        end else begin
          root = {root[W-2:0], 1'b0};
        end
      end
      rem_d[k]  = rem;
      root_d[k] = root;
      rad_d[k]  = rad;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < S; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      rad_q[k]  <= rad_d[k];
    end
    // round up when the remainder exceeds the root
    root_out_q <= {1'b0, root_q[S-1]}
                + vfa_pkg::LEN_W'(rem_q[S-1] > {2'b00, root_q[S-1]});
  end

  assign root_o = root_out_q;

endmodule

// ===== src/vfa_div.sv =====
// ----------------------------------------------------------------------------
// vfa_div
// Pipelined divider lane for normalize: (num << FRAC_BITS) / den, with
// num <= den, rounded half away from zero on the magnitude.
// ----------------------------------------------------------------------------
module vfa_div (
  input  logic                              clk_i,
  input  logic [vfa_pkg::WORD_BITS-1:0]     num_i,
  input  logic [vfa_pkg::LEN_W-1:0]         den_i,
  output logic [vfa_pkg::QUO_W-1:0]         quo_o
);

  localparam int W = vfa_pkg::WORD_BITS;
  localparam int F = vfa_pkg::FRAC_BITS;
  localparam int S = vfa_pkg::DIV_STAGES;

  logic [W+1:0]                 rem_q [S];
  logic [vfa_pkg::QUO_W-1:0]    quo_q [S];
  logic [vfa_pkg::LEN_W-1:0]    den_q [S];
  logic                         lsb_q [S];
  logic [W+1:0]                 rem_d [S];
  logic [vfa_pkg::QUO_W-1:0]    quo_d [S];
  logic [vfa_pkg::LEN_W-1:0]    den_d [S];
  logic                         lsb_d [S];

  always_comb begin : stage_comb
    logic [W+1:0]              rem;
    logic [vfa_pkg::QUO_W-1:0] quo;
    logic [vfa_pkg::LEN_W-1:0] den;
    logic                      lsb;
    logic                      nbit;
    int                        idx;
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        // upper numerator bits are num >> 1, already below den
        rem = (W+2)'(num_i >> 1);
        quo = '0;
        den = den_i;
        lsb = num_i[0];
      end else begin
        rem = rem_q[k-1];
        quo = quo_q[k-1];
        den = den_q[k-1];
        lsb = lsb_q[k-1];
      end
      for (int j = 0; j < vfa_pkg::DIV_STEPS_PER; j++) begin
        idx = k * vfa_pkg::DIV_STEPS_PER + j;
        if (idx < vfa_pkg::DIV_STEPS) begin
          nbit = (idx == 0) ? lsb : 1'b0;
          rem  = {rem[W:0], nbit};
          if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo = {quo[F-1:0], 1'b1};
          end else begin
            quo = {quo[F-1:0], 1'b0};
          end
        end
      end
      if (k == S - 1) begin
        if ({rem[W:0], 1'b0} >= {1'b0, den}) begin
          quo = quo + 1'b1;
        end
      end
      rem_d[k] = rem;
      quo_d[k] = quo;
      den_d[k] = den;
      lsb_d[k] = lsb;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < S; k++) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      den_q[k] <= den_d[k];
      lsb_q[k] <= lsb_d[k];
    end
  end

  assign quo_o = quo_q[S-1];

endmodule

// ===== src/vector3_fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_unit
// Pipeline: the result strobe follows the accepting edge through 20 register
//   stages: input capture, operand prep, multiply, combine, 9 square-root
//   stages, 6 divider stages, output.
// Throughput: one transaction per cycle; busy stays low.
// Reset clears the valid pipeline and the threshold register.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  vfa_pkg::in_t                    item_i,
  output logic                            result_valid_o,
  output vfa_pkg::out_t                   result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vfa_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [vfa_pkg::DATA_BITS-1:0]   pwdata,
  output logic [vfa_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  localparam int W     = vfa_pkg::WORD_BITS;
  localparam int OPD_W = vfa_pkg::OPD_W;
  localparam int RES_W = vfa_pkg::RES_W;
  localparam int SUM_W = vfa_pkg::SUM_W;
  localparam int NZ_W  = vfa_pkg::NZ_W;
  localparam int N     = vfa_pkg::SIDE_N;

  typedef struct packed {
    logic [3:0]               op;
    logic [2:0][OPD_W-1:0]    e;
    logic [2:0][W-1:0]        av;
    logic                     eq;
    logic                     nz_all;
    vfa_pkg::axis_e           axis;
    logic                     axis_neg;
    logic [2:0][W-1:0]        amag;
    logic [2:0]               aneg;
  } ctl_t;

  typedef struct packed {
    logic [5:0][OPD_W-1:0] ma;
    logic [5:0][OPD_W-1:0] mb;
  } opd_t;

  typedef struct packed {
    logic [3:0]               op;
    logic [2:0][RES_W-1:0]    r;
    logic [RES_W-1:0]         sc;
    logic                     eq;
    logic                     nz_all;
    vfa_pkg::axis_e           axis;
    logic                     axis_neg;
    logic [2:0][W-1:0]        amag;
    logic [2:0]               aneg;
  } side_t;

  // ---------------- configuration ----------------
  logic [vfa_pkg::THR_BITS-1:0] thr_q;
  logic                         thr_sel;

  assign thr_sel = (paddr[vfa_pkg::ADDR_BITS-1:2] == vfa_pkg::REG_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = thr_sel ? vfa_pkg::DATA_BITS'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && thr_sel) begin
      thr_q <= pwdata[vfa_pkg::THR_BITS-1:0];
    end
  end

  // ---------------- pipeline registers ----------------
  vfa_pkg::in_t  in_q;
  logic          in_vld_q;
  opd_t          opd_d, opd_q;
  ctl_t          ctl_d, prep_ctl_q, prod_ctl_q;
  logic          prep_vld_q, prod_vld_q;
  logic [5:0][vfa_pkg::PROD_W-1:0] prod_q;
  side_t         side_d;
  side_t         side_q [N];
  logic [N-1:0]  side_vld_q;
  logic [2*W-1:0] sqn_d, sqn_q;
  logic [vfa_pkg::LEN_W-1:0] len;
  logic [vfa_pkg::LEN_W-1:0] len_dly_q [vfa_pkg::DIV_LAT];
  logic [2:0][vfa_pkg::QUO_W-1:0] quo;
  vfa_pkg::out_t result_d, result_q;
  logic          result_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      prep_vld_q   <= 1'b0;
      prod_vld_q   <= 1'b0;
      side_vld_q   <= '0;
      result_vld_q <= 1'b0;
    end else begin
      in_vld_q     <= start && !busy;
      prep_vld_q   <= in_vld_q;
      prod_vld_q   <= prep_vld_q;
      side_vld_q   <= {side_vld_q[N-2:0], prod_vld_q};
      result_vld_q <= side_vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
    opd_q      <= opd_d;
    prep_ctl_q <= ctl_d;
    for (int k = 0; k < 6; k++) begin
      prod_q[k] <= vfa_pkg::PROD_W'($signed(opd_q.ma[k]) * $signed(opd_q.mb[k]));
    end
    prod_ctl_q <= prep_ctl_q;
    sqn_q      <= sqn_d;
    side_q[0]  <= side_d;
    for (int k = 1; k < N; k++) begin
      side_q[k] <= side_q[k-1];
    end
    len_dly_q[0] <= len;
    for (int k = 1; k < vfa_pkg::DIV_LAT; k++) begin
      len_dly_q[k] <= len_dly_q[k-1];
    end
    result_q <= result_d;
  end

  // ---------------- operand prep ----------------
  always_comb begin : prep_comb
    logic signed [W-1:0]     av [3];
    logic signed [W-1:0]     bv [3];
    logic signed [OPD_W-1:0] dba [3];
    logic signed [OPD_W-1:0] dab [3];
    logic signed [W-1:0]     x, y, z;
    opd_d = '0;
    ctl_d = '0;
    av[0] = in_q.a_x;
    av[1] = in_q.a_y;
    av[2] = in_q.a_z;
    bv[0] = in_q.b_x;
    bv[1] = in_q.b_y;
    bv[2] = in_q.b_z;
    ctl_d.op = in_q.op;
    for (int i = 0; i < 3; i++) begin
      dba[i] = OPD_W'(bv[i]) - OPD_W'(av[i]);
      dab[i] = OPD_W'(av[i]) - OPD_W'(bv[i]);
      ctl_d.av[i]   = av[i];
      ctl_d.aneg[i] = av[i][W-1];
      ctl_d.amag[i] = av[i][W-1] ? (~av[i] + 1'b1) : av[i];
    end
    ctl_d.nz_all = vfa_pkg::near_zero(NZ_W'(av[0]), thr_q)
                && vfa_pkg::near_zero(NZ_W'(av[1]), thr_q)
                && vfa_pkg::near_zero(NZ_W'(av[2]), thr_q);

    // unit axis fallback, first matching rule wins
    x = av[0];
    y = av[1];
    z = av[2];
    if (x >= y && x >= z && x >= 0) begin
      ctl_d.axis = vfa_pkg::AXIS_X;
      ctl_d.axis_neg = 1'b0;
    end else if (x <= y && x <= z && x <= 0) begin
      ctl_d.axis = vfa_pkg::AXIS_X;
      ctl_d.axis_neg = 1'b1;
    end else if (y >= z && y >= 0) begin
      ctl_d.axis = vfa_pkg::AXIS_Y;
      ctl_d.axis_neg = 1'b0;
    end else if (y <= z && y <= 0) begin
      ctl_d.axis = vfa_pkg::AXIS_Y;
      ctl_d.axis_neg = 1'b1;
    end else begin
      ctl_d.axis = vfa_pkg::AXIS_Z;
      ctl_d.axis_neg = z < 0;
    end

    unique case (vfa_pkg::op_e'(in_q.op))
      vfa_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) ctl_d.e[i] = OPD_W'(av[i]) + OPD_W'(bv[i]);
      end
      vfa_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) ctl_d.e[i] = dab[i];
      end
      vfa_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) ctl_d.e[i] = -OPD_W'(av[i]);
      end
      vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opd_d.ma[i] = OPD_W'(av[i]);
          opd_d.mb[i] = OPD_W'(in_q.scalar_in);
        end
      end
      vfa_pkg::OP_CROSS: begin
        opd_d.ma[0] = OPD_W'(av[1]);  opd_d.mb[0] = OPD_W'(bv[2]);
        opd_d.ma[3] = OPD_W'(av[2]);  opd_d.mb[3] = OPD_W'(bv[1]);
        opd_d.ma[1] = OPD_W'(av[2]);  opd_d.mb[1] = OPD_W'(bv[0]);
        opd_d.ma[4] = OPD_W'(av[0]);  opd_d.mb[4] = OPD_W'(bv[2]);
        opd_d.ma[2] = OPD_W'(av[0]);  opd_d.mb[2] = OPD_W'(bv[1]);
        opd_d.ma[5] = OPD_W'(av[1]);  opd_d.mb[5] = OPD_W'(bv[0]);
      end
      vfa_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opd_d.ma[i] = OPD_W'(av[i]);
          opd_d.mb[i] = OPD_W'(bv[i]);
        end
      end
      vfa_pkg::OP_LENGTH, vfa_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opd_d.ma[i] = OPD_W'(av[i]);
          opd_d.mb[i] = OPD_W'(av[i]);
        end
      end
      vfa_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          opd_d.ma[i] = dba[i];
          opd_d.mb[i] = OPD_W'(in_q.scalar_in);
        end
      end
      vfa_pkg::OP_EQUAL: begin
        ctl_d.eq = vfa_pkg::near_zero(NZ_W'(dab[0]), thr_q)
                && vfa_pkg::near_zero(NZ_W'(dab[1]), thr_q)
                && vfa_pkg::near_zero(NZ_W'(dab[2]), thr_q);
      end
      default: begin
        ctl_d.op = in_q.op;
      end
    endcase
  end

  // ---------------- combine and round ----------------
  always_comb begin : sum_comb
    logic signed [SUM_W-1:0] ps [6];
    logic signed [SUM_W-1:0] sum3;
    for (int k = 0; k < 6; k++) ps[k] = SUM_W'($signed(prod_q[k]));
    sum3 = ps[0] + ps[1] + ps[2];
    sqn_d = sum3[2*W-1:0];

    side_d          = '0;
    side_d.op       = prod_ctl_q.op;
    side_d.eq       = prod_ctl_q.eq;
    side_d.nz_all   = prod_ctl_q.nz_all;
    side_d.axis     = prod_ctl_q.axis;
    side_d.axis_neg = prod_ctl_q.axis_neg;
    side_d.amag     = prod_ctl_q.amag;
    side_d.aneg     = prod_ctl_q.aneg;
    case (vfa_pkg::op_e'(prod_ctl_q.op))
      vfa_pkg::OP_ADD, vfa_pkg::OP_SUB, vfa_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) side_d.r[i] = RES_W'($signed(prod_ctl_q.e[i]));
      end
      vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) side_d.r[i] = vfa_pkg::round_q(ps[i]);
      end
      vfa_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) side_d.r[i] = vfa_pkg::round_q(ps[i] - ps[i+3]);
      end
      vfa_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          side_d.r[i] = vfa_pkg::round_q(ps[i]) + RES_W'($signed(prod_ctl_q.av[i]));
        end
      end
      vfa_pkg::OP_DOT: begin
        side_d.sc = vfa_pkg::round_q(sum3);
      end
      default: begin
        side_d.sc = '0;
      end
    endcase
  end

  // ---------------- length and normalize ----------------
  vfa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sqn_q),
    .root_o (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    vfa_div u_div (
      .clk_i (clk_i),
      .num_i (side_q[vfa_pkg::SQRT_LAT].amag[g]),
      .den_i (len),
      .quo_o (quo[g])
    );
  end

  // ---------------- select and saturate ----------------
  always_comb begin : out_comb
    side_t                    s;
    logic [vfa_pkg::LEN_W-1:0] l;
    logic signed [RES_W-1:0]  r [3];
    logic signed [RES_W-1:0]  sc;
    logic signed [RES_W-1:0]  unit;
    logic                     eq;
    s  = side_q[N-1];
    l  = len_dly_q[vfa_pkg::DIV_LAT-1];
    for (int i = 0; i < 3; i++) r[i] = $signed(s.r[i]);
    sc   = $signed(s.sc);
    eq   = s.eq;
    unit = s.axis_neg ? -vfa_pkg::ONE_RES : vfa_pkg::ONE_RES;
    case (vfa_pkg::op_e'(s.op))
      vfa_pkg::OP_LENGTH: begin
        sc = RES_W'(l);
      end
      vfa_pkg::OP_NORM: begin
        if (s.nz_all) begin
          for (int i = 0; i < 3; i++) r[i] = '0;
        end else if (vfa_pkg::near_zero($signed({1'b0, l}), thr_q)) begin
          for (int i = 0; i < 3; i++) r[i] = '0;
          unique case (s.axis)
            vfa_pkg::AXIS_X: r[0] = unit;
            vfa_pkg::AXIS_Y: r[1] = unit;
            vfa_pkg::AXIS_Z: r[2] = unit;
            default:         r[2] = unit;
          endcase
        end else begin
          for (int i = 0; i < 3; i++) begin
            r[i] = s.aneg[i] ? -RES_W'(quo[i]) : RES_W'(quo[i]);
          end
        end
      end
      default: begin
        eq = s.eq;
      end
    endcase
    result_d.r_x        = vfa_pkg::sat_word(r[0]);
    result_d.r_y        = vfa_pkg::sat_word(r[1]);
    result_d.r_z        = vfa_pkg::sat_word(r[2]);
    result_d.scalar_out = vfa_pkg::sat_word(sc);
    result_d.equal_flag = eq;
    result_d.saturated  = vfa_pkg::is_clipped(r[0]) || vfa_pkg::is_clipped(r[1])
                       || vfa_pkg::is_clipped(r[2]) || vfa_pkg::is_clipped(sc);
  end

  assign result_valid_o = result_vld_q;
  assign result_o       = result_q;

endmodule

// ===== src/vfa_checker.sv =====
// ----------------------------------------------------------------------------
// vfa_checker
// Port-level checks of the vector ALU: fixed latency, flag consistency and
// threshold register readback.
// ----------------------------------------------------------------------------
module vfa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid_o,
  input vfa_pkg::out_t                   result_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [vfa_pkg::ADDR_BITS-1:0]   paddr,
  input logic [vfa_pkg::DATA_BITS-1:0]   pwdata,
  input logic [vfa_pkg::DATA_BITS-1:0]   prdata
);

  logic thr_wr;
  logic thr_sel;

  assign thr_sel = (paddr[vfa_pkg::ADDR_BITS-1:2] == vfa_pkg::REG_THRESHOLD);
  assign thr_wr  = psel && penable && pwrite && thr_sel;

  // every accepted transaction yields exactly one result after a fixed delay
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(vfa_pkg::PIPE_LAT) result_valid_o)
    else $error("accepted transaction produced no result");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, vfa_pkg::PIPE_LAT))
    else $error("result without an accepted transaction");

  // equality results carry no vector, scalar or clip
  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.equal_flag |->
      result_o.r_x == '0 && result_o.r_y == '0 && result_o.r_z == '0 &&
      result_o.scalar_out == '0 && !result_o.saturated)
    else $error("equal flag with nonzero payload");

  a_thr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(thr_wr) && thr_sel |->
      prdata == vfa_pkg::DATA_BITS'($past(pwdata[vfa_pkg::THR_BITS-1:0])))
    else $error("threshold readback mismatch");

endmodule

bind vector3_fixed_point_alu_unit vfa_checker u_vfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3D fixed-point vector ALU. Directed corner
// vectors and random vector streams are fed through the command port while
// the near-zero threshold is reprogrammed over APB between phases. Every
// result is compared field by field against a wide-integer golden
// computation of the same operation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  vfa_pkg::in_t item_i = '0;
  logic result_valid_o;
  vfa_pkg::out_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vfa_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [vfa_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [vfa_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  vector3_fixed_point_alu_unit dut (.*);

  always #4 clk_i = ~clk_i;

  vfa_pkg::in_t pending_items[$];
  vfa_pkg::out_t expected_results[$];
  logic [vfa_pkg::THR_BITS-1:0] threshold = '0;
  int idle_pct = 0;
  logic took = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;

  // ---------------------------------------------------------------- golden
  function automatic logic is_small(input logic signed [127:0] v);
    logic signed [127:0] t;
    t = 128'(threshold);
    return (v == 0) || (v > 0 ? v < t : -v < t);
  endfunction

  function automatic logic signed [31:0] clip_word(input logic signed [127:0] v,
                                                    inout logic clipped);
    if (v > 128'sh7FFF_FFFF) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] round_fix(input logic signed [127:0] v);
    return (v + (128'sd1 <<< (vfa_pkg::FRAC_BITS - 1))) >>> vfa_pkg::FRAC_BITS;
  endfunction

  function automatic logic [127:0] root_nearest(input logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= n) r = c;
    end
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic vfa_pkg::out_t vector_alu_result(input vfa_pkg::in_t it);
    logic signed [127:0] a[3], b[3], r[3], s, sc, one;
    logic [127:0] len, num, q, rem;
    logic clipped, eq;
    vfa_pkg::out_t o;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
    s = it.scalar_in;
    r[0] = 0; r[1] = 0; r[2] = 0;
    sc = 0;
    clipped = 1'b0;
    eq = 1'b0;
    one = 128'sd1 <<< vfa_pkg::FRAC_BITS;
    case (vfa_pkg::op_e'(it.op))
      vfa_pkg::OP_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      vfa_pkg::OP_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      vfa_pkg::OP_NEG:   for (int i = 0; i < 3; i++) r[i] = -a[i];
      vfa_pkg::OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_fix(a[i] * s);
      vfa_pkg::OP_CROSS: begin
        r[0] = round_fix(a[1] * b[2] - a[2] * b[1]);
        r[1] = round_fix(a[2] * b[0] - a[0] * b[2]);
        r[2] = round_fix(a[0] * b[1] - a[1] * b[0]);
      end
      vfa_pkg::OP_DOT:    sc = round_fix(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      vfa_pkg::OP_LENGTH: sc = root_nearest(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      vfa_pkg::OP_NORM: begin
        if (!(is_small(a[0]) && is_small(a[1]) && is_small(a[2]))) begin
          len = root_nearest(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
          if (is_small(len)) begin
            // signed unit axis, first matching rule wins
            if (a[0] >= a[1] && a[0] >= a[2] && a[0] >= 0) r[0] = one;
            else if (a[0] <= a[1] && a[0] <= a[2] && a[0] <= 0) r[0] = -one;
            else if (a[1] >= a[2] && a[1] >= 0) r[1] = one;
            else if (a[1] <= a[2] && a[1] <= 0) r[1] = -one;
            else r[2] = (a[2] >= 0) ? one : -one;
          end else begin
            for (int i = 0; i < 3; i++) begin
              num = (a[i] < 0 ? -a[i] : a[i]) << vfa_pkg::FRAC_BITS;
              q = num / len;
              rem = num % len;
              if (rem >= len - rem) q = q + 1;
              r[i] = (a[i] < 0) ? -$signed(q) : $signed(q);
            end
          end
        end
      end
      vfa_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) r[i] = round_fix((b[i] - a[i]) * s) + a[i];
      end
      vfa_pkg::OP_EQUAL: begin
        eq = is_small(a[0] - b[0]) && is_small(a[1] - b[1]) && is_small(a[2] - b[2]);
      end
      default: ;
    endcase
    o.r_x = clip_word(r[0], clipped);
    o.r_y = clip_word(r[1], clipped);
    o.r_z = clip_word(r[2], clipped);
    o.scalar_out = clip_word(sc, clipped);
    o.equal_flag = eq;
    o.saturated = clipped;
    return o;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !took) begin
        // hold until the transaction is taken
      end else if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item_i <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    vfa_pkg::out_t exp_r;
    took <= start && !busy;
    if (rst_ni && start && !busy) begin
      expected_results.push_back(vector_alu_result(item_i));
      n_items++;
    end
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", result_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_o.r_x !== exp_r.r_x) begin
          $error("r_x exp %h got %h", exp_r.r_x, result_o.r_x); errors++;
        end
        if (result_o.r_y !== exp_r.r_y) begin
          $error("r_y exp %h got %h", exp_r.r_y, result_o.r_y); errors++;
        end
        if (result_o.r_z !== exp_r.r_z) begin
          $error("r_z exp %h got %h", exp_r.r_z, result_o.r_z); errors++;
        end
        if (result_o.scalar_out !== exp_r.scalar_out) begin
          $error("scalar_out exp %h got %h", exp_r.scalar_out, result_o.scalar_out);
          errors++;
        end
        if (result_o.equal_flag !== exp_r.equal_flag) begin
          $error("equal_flag exp %b got %b", exp_r.equal_flag, result_o.equal_flag);
          errors++;
        end
        if (result_o.saturated !== exp_r.saturated) begin
          $error("saturated exp %b got %b", exp_r.saturated, result_o.saturated);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic write_threshold(input logic [vfa_pkg::THR_BITS-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {vfa_pkg::REG_THRESHOLD, 2'b00};
    pwdata <= vfa_pkg::DATA_BITS'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    threshold = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2: return 32'($signed($urandom_range(2 ** 21)) - 2 ** 20);
      3: return 32'($signed($urandom_range(140000)) - 70000);
      4: begin
        case ($urandom_range(5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'h1;
        endcase
      end
      default: return 32'($signed($urandom_range(2 ** 27)) - 2 ** 26);
    endcase
  endfunction

  task automatic add_item(input vfa_pkg::op_e op,
                          input logic [31:0] ax, ay, az, bx, by, bz, s);
    vfa_pkg::in_t it;
    it.op = op;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = bx; it.b_y = by; it.b_z = bz;
    it.scalar_in = s;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    vfa_pkg::in_t it;
    logic [vfa_pkg::THR_BITS-1:0] thr_plan[4];
    int idle_plan[4];
    thr_plan[0] = 16'd0;
    thr_plan[1] = 16'hFFFF;
    thr_plan[2] = 16'($urandom());
    thr_plan[3] = 16'd1;
    idle_plan[0] = 0; idle_plan[1] = 76; idle_plan[2] = 0; idle_plan[3] = 36;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_plan[ph]);
      idle_pct = idle_plan[ph];
      if (ph == 0) begin
        add_item(vfa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                 32'h7FFF_FFFF, 32'h8000_0000, -1, 0);
        add_item(vfa_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_item(vfa_pkg::OP_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                 0, 0, 0, 32'h7FFF_FFFF);
        add_item(vfa_pkg::OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 3, 0, 0, 0,
                 32'h0000_8000);
        add_item(vfa_pkg::OP_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_item(vfa_pkg::OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0);
        add_item(vfa_pkg::OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_item(vfa_pkg::OP_DOT, 32'h18000, 32'hFFFE_0000, 5, 32'h20000, 32'h8000, 7, 0);
        add_item(vfa_pkg::OP_LENGTH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 0, 0, 0, 0);
        add_item(vfa_pkg::OP_LENGTH, 32'h30000, 32'h40000, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 32'h30000, 32'hFFFC_0000, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 0, 0, 0, 0);
        add_item(vfa_pkg::OP_LERP, 0, 32'h10000, 32'h8000_0000, 32'h20000, 32'h30000,
                 32'h7FFF_FFFF, 32'h8000);
        add_item(vfa_pkg::OP_LERP, 32'h8000_0000, 0, 5, 32'h7FFF_FFFF, 0, 5,
                 32'h7FFF_FFFF);
        add_item(vfa_pkg::OP_EQUAL, 32'h12345, 32'h8000_0000, 0,
                 32'h12345, 32'h8000_0000, 0, 0);
        add_item(vfa_pkg::OP_EQUAL, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        add_item(vfa_pkg::op_e'(4'd15), 32'h7FFF_FFFF, 1, 2, 3, 4, 5, 6);
      end
      for (int n = 0; n < 500; n++) begin
        it.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                          : 4'($urandom_range(9));
        it.a_x = random_word(); it.a_y = random_word(); it.a_z = random_word();
        it.b_x = random_word(); it.b_y = random_word(); it.b_z = random_word();
        it.scalar_in = random_word();
        // make near-equal pairs common so the threshold decides the flag
        if (it.op == vfa_pkg::OP_EQUAL && $urandom_range(1)) begin
          it.b_x = it.a_x + 32'($signed($urandom_range(2 * thr_plan[ph] + 2))
                                - thr_plan[ph] - 1);
          it.b_y = it.a_y + 32'($signed($urandom_range(2 * thr_plan[ph] + 2))
                                - thr_plan[ph] - 1);
          it.b_z = it.a_z + 32'($signed($urandom_range(2 * thr_plan[ph] + 2))
                                - thr_plan[ph] - 1);
        end
        pending_items.push_back(it);
      end
      drain();
    end

    $display("Ran %0d vector operations over four threshold settings and idle patterns;",
             n_items);
    $display("%0d results checked, %0d mismatches.", n_results, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
